### rtl/gbes_pkg.sv
// Shared constants and types for the gap buffer text store.
package gbes_pkg;

  localparam int CAPACITY = 4096;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 13;
  localparam int CHAR_W   = 8;
  localparam int MODE_W   = 2;
  localparam int STAT_W   = 2;
  localparam int IN_W     = 24;
  localparam int OUT_W    = 24;

  localparam logic [MODE_W-1:0] MODE_INSERT     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEL_BEFORE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DEL_AT     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ       = 2'd3;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic load;
    logic check;
    logic move_rd;
    logic move_wr;
    logic edit;
    logic emit;
  } gbes_cmd_t;

  typedef struct packed {
    logic chk_err;
    logic is_read;
    logic at_target;
    logic out_free;
  } gbes_sts_t;

endpackage

### rtl/gbes_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module gbes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/gbes_ctrl.sv
// Controller state machine that sequences checking, gap moves, edits and results.
module gbes_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gbes_pkg::gbes_sts_t sts,
  output gbes_pkg::gbes_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CHECK   = 6'b000010,
    S_MOVE_RD = 6'b000100,
    S_MOVE_WR = 6'b001000,
    S_EDIT    = 6'b010000,
    S_DONE    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        if (sts.chk_err || sts.is_read) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MOVE_RD;
        end
      end
      S_MOVE_RD: begin
        if (sts.at_target) begin
          state_nxt = S_EDIT;
        end else begin
          cmd.move_rd = 1'b1;
          state_nxt   = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        cmd.move_wr = 1'b1;
        state_nxt   = S_MOVE_RD;
      end
      S_EDIT: begin
        cmd.edit  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/gbes_dp.sv
// Datapath holding the two stacks, their counts, the request and the result register.
module gbes_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  gbes_pkg::gbes_cmd_t                  cmd,
  output gbes_pkg::gbes_sts_t                  sts,
  input  logic [gbes_pkg::MODE_W-1:0]          mode_in,
  input  logic [gbes_pkg::CNT_W-1:0]           position_in,
  input  logic [gbes_pkg::CHAR_W-1:0]          char_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [gbes_pkg::CHAR_W-1:0]          char_out,
  output logic [gbes_pkg::STAT_W-1:0]          status_out,
  output logic [gbes_pkg::CNT_W-1:0]           text_length
);

  logic [gbes_pkg::MODE_W-1:0] mode_r;
  logic [gbes_pkg::CNT_W-1:0]  pos_r;
  logic [gbes_pkg::CHAR_W-1:0] ch_r;
  logic [gbes_pkg::CNT_W-1:0]  pc_r, pc_nxt;
  logic [gbes_pkg::CNT_W-1:0]  sc_r, sc_nxt;
  logic [gbes_pkg::CNT_W-1:0]  target_r;
  logic [gbes_pkg::STAT_W-1:0] err_r;
  logic                        dir_left_r;
  logic                        sel_sfx_r;
  logic                        out_valid_r;
  logic [gbes_pkg::CHAR_W-1:0] out_char_r;
  logic [gbes_pkg::STAT_W-1:0] out_stat_r;
  logic [gbes_pkg::CNT_W-1:0]  out_len_r;

  logic [gbes_pkg::CNT_W-1:0]  total;
  logic [gbes_pkg::STAT_W-1:0] chk_code;
  logic [gbes_pkg::CNT_W-1:0]  chk_target;
  logic                        is_read;
  logic                        rd_sfx;
  logic [gbes_pkg::CNT_W-1:0]  sfx_rd_idx;
  logic                        move_left;
  logic [gbes_pkg::CNT_W-1:0]  pc_dec;
  logic [gbes_pkg::CNT_W-1:0]  sc_dec;

  logic                        pfx_we, pfx_re, sfx_we, sfx_re;
  logic [gbes_pkg::ADDR_W-1:0] pfx_waddr, pfx_raddr, sfx_waddr, sfx_raddr;
  logic [gbes_pkg::CHAR_W-1:0] pfx_wdata, pfx_rdata, sfx_wdata, sfx_rdata;

  assign total      = pc_r + sc_r;
  assign is_read    = (mode_r == gbes_pkg::MODE_READ);
  assign rd_sfx     = (pos_r >= pc_r);
  assign sfx_rd_idx = sc_r - 13'd1 - (pos_r - pc_r);
  assign move_left  = (pc_r > target_r);
  assign pc_dec     = pc_r - 13'd1;
  assign sc_dec     = sc_r - 13'd1;

  always_comb begin
    chk_code   = gbes_pkg::ST_DONE;
    chk_target = pos_r;
    unique case (mode_r)
      gbes_pkg::MODE_INSERT: begin
        if (pos_r > total) begin
          chk_code = gbes_pkg::ST_RANGE;
        end else if (total >= gbes_pkg::CNT_W'(gbes_pkg::CAPACITY)) begin
          chk_code = gbes_pkg::ST_FULL;
        end
      end
      gbes_pkg::MODE_DEL_BEFORE: begin
        if (total == '0 || pos_r == '0 || pos_r > total) begin
          chk_code = gbes_pkg::ST_RANGE;
        end
      end
      gbes_pkg::MODE_DEL_AT: begin
        chk_target = pos_r + 13'd1;
        if (pos_r >= total) begin
          chk_code = gbes_pkg::ST_RANGE;
        end
      end
      gbes_pkg::MODE_READ: begin
        if (pos_r >= total) begin
          chk_code = gbes_pkg::ST_RANGE;
        end
      end
      default: begin
        chk_code = gbes_pkg::ST_RANGE;
      end
    endcase
  end

  assign sts.chk_err   = (chk_code != gbes_pkg::ST_DONE);
  assign sts.is_read   = is_read;
  assign sts.at_target = (pc_r == target_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  // Stack port selection.
  assign pfx_re    = (cmd.check && is_read && !sts.chk_err && !rd_sfx)
                     || (cmd.move_rd && move_left);
  assign pfx_raddr = cmd.check ? pos_r[gbes_pkg::ADDR_W-1:0]
                               : pc_dec[gbes_pkg::ADDR_W-1:0];
  assign sfx_re    = (cmd.check && is_read && !sts.chk_err && rd_sfx)
                     || (cmd.move_rd && !move_left);
  assign sfx_raddr = cmd.check ? sfx_rd_idx[gbes_pkg::ADDR_W-1:0]
                               : sc_dec[gbes_pkg::ADDR_W-1:0];

  assign pfx_we    = (cmd.move_wr && !dir_left_r)
                     || (cmd.edit && mode_r == gbes_pkg::MODE_INSERT);
  assign pfx_waddr = pc_r[gbes_pkg::ADDR_W-1:0];
  assign pfx_wdata = cmd.edit ? ch_r : sfx_rdata;
  assign sfx_we    = cmd.move_wr && dir_left_r;
  assign sfx_waddr = sc_r[gbes_pkg::ADDR_W-1:0];
  assign sfx_wdata = pfx_rdata;

  gbes_ram #(
    .WIDTH (gbes_pkg::CHAR_W),
    .DEPTH (gbes_pkg::CAPACITY)
  ) u_prefix_ram (
    .clk   (clk),
    .we    (pfx_we),
    .waddr (pfx_waddr),
    .wdata (pfx_wdata),
    .re    (pfx_re),
    .raddr (pfx_raddr),
    .rdata (pfx_rdata)
  );

  gbes_ram #(
    .WIDTH (gbes_pkg::CHAR_W),
    .DEPTH (gbes_pkg::CAPACITY)
  ) u_suffix_ram (
    .clk   (clk),
    .we    (sfx_we),
    .waddr (sfx_waddr),
    .wdata (sfx_wdata),
    .re    (sfx_re),
    .raddr (sfx_raddr),
    .rdata (sfx_rdata)
  );

  always_comb begin
    pc_nxt = pc_r;
    sc_nxt = sc_r;
    if (cmd.move_wr) begin
      if (dir_left_r) begin
        pc_nxt = pc_r - 13'd1;
        sc_nxt = sc_r + 13'd1;
      end else begin
        pc_nxt = pc_r + 13'd1;
        sc_nxt = sc_r - 13'd1;
      end
    end else if (cmd.edit) begin
      if (mode_r == gbes_pkg::MODE_INSERT) begin
        pc_nxt = pc_r + 13'd1;
      end else begin
        pc_nxt = pc_r - 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      sc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      sc_r <= sc_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= mode_in;
      pos_r  <= position_in;
      ch_r   <= char_in;
    end
    if (cmd.check) begin
      err_r     <= chk_code;
      target_r  <= chk_target;
      sel_sfx_r <= rd_sfx;
    end
    if (cmd.move_rd) begin
      dir_left_r <= move_left;
    end
    if (cmd.emit) begin
      out_stat_r <= err_r;
      out_len_r  <= total;
      if (is_read && err_r == gbes_pkg::ST_DONE) begin
        out_char_r <= sel_sfx_r ? sfx_rdata : pfx_rdata;
      end else begin
        out_char_r <= '0;
      end
    end
  end

  assign out_valid   = out_valid_r;
  assign char_out    = out_char_r;
  assign status_out  = out_stat_r;
  assign text_length = out_len_r;

  a_total_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    total <= gbes_pkg::CNT_W'(gbes_pkg::CAPACITY))
    else $error("text length exceeds the capacity");

  a_move_keeps_total: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move_wr |=> total == $past(total))
    else $error("a gap move changed the text length");

  a_move_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move_wr |=> (pc_r == $past(pc_r) + 13'd1) || (pc_r == $past(pc_r) - 13'd1))
    else $error("a gap move did not shift exactly one byte");

  a_char_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && !is_read) |=> out_char_r == '0)
    else $error("a non-read transaction returned a character");

endmodule

### rtl/gap_buffer_editor_store.sv
// Top level of the gap buffer text store: controller, datapath and stream ports.
// Each input transaction applies one operation (insert, delete before, delete at or read)
// at a character position of a text of up to 4096 bytes and returns one result transaction.
// A read, or any request rejected with an error status, skips the gap move and the edit. An
// edit first moves the gap d bytes, where d is the distance from the cursor left by the
// previous edit: each byte crosses the gap by one read of one stack RAM and one write to
// the other. The next transaction is accepted while an earlier result still waits to be taken.
module gap_buffer_editor_store (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [gbes_pkg::IN_W-1:0]  in_tdata,   // mode[1:0], position[14:2], char_in[22:15]
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [gbes_pkg::OUT_W-1:0] out_tdata   // char_out[7:0], status[9:8], text_length[22:10]
);

  gbes_pkg::gbes_cmd_t cmd;
  gbes_pkg::gbes_sts_t sts;

  logic [gbes_pkg::CHAR_W-1:0] char_out;
  logic [gbes_pkg::STAT_W-1:0] status_out;
  logic [gbes_pkg::CNT_W-1:0]  text_length;

  gbes_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gbes_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .mode_in     (in_tdata[1:0]),
    .position_in (in_tdata[14:2]),
    .char_in     (in_tdata[22:15]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .char_out    (char_out),
    .status_out  (status_out),
    .text_length (text_length)
  );

  assign out_tdata = {1'b0, text_length, status_out, char_out};

endmodule
